// ===== hdl/mseg_pkg.sv =====
// Shared types, codes and microcode word layout of the envelope generator.
`default_nettype none

package mseg_pkg;

    // Port widths
    localparam int S_TDATA_W  = 16;   // velocity
    localparam int S_TUSER_W  = 2;    // command
    localparam int M_TDATA_W  = 40;   // sample, stage, active, stage_changed, pad
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int LEVEL_W = 32;
    localparam int VEL_W   = 16;
    localparam int STAGE_W = 3;
    localparam int PROD_W  = 64;

    localparam logic [VEL_W-1:0] ONE_Q15 = 16'h8000;

    // Stage codes
    localparam logic [STAGE_W-1:0] STG_OFF      = 3'd0;
    localparam logic [STAGE_W-1:0] STG_HOLD     = 3'd1;
    localparam logic [STAGE_W-1:0] STG_ATTACK   = 3'd2;
    localparam logic [STAGE_W-1:0] STG_DECAY1   = 3'd3;
    localparam logic [STAGE_W-1:0] STG_DECAY2   = 3'd4;
    localparam logic [STAGE_W-1:0] STG_SUSTAIN  = 3'd5;
    localparam logic [STAGE_W-1:0] STG_RELEASE1 = 3'd6;
    localparam logic [STAGE_W-1:0] STG_RELEASE2 = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 3'd7;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_RESET   = 2'd3
    } cmd_t;

    // Microprogram steps
    typedef enum logic [2:0] {
        STEP_FETCH = 3'd0,
        STEP_APPLY = 3'd1,
        STEP_SCALE = 3'd2,
        STEP_LEVEL = 3'd3,
        STEP_PROD  = 3'd4,
        STEP_OUT   = 3'd5
    } step_t;

    typedef enum logic [1:0] {
        MUL_NONE        = 2'd0,
        MUL_DEPTH_VEL   = 2'd1,
        MUL_LEVEL_COEF  = 2'd2,
        MUL_LEVEL_SCALE = 2'd3
    } mul_sel_t;

    typedef enum logic [1:0] {
        COND_NEXT     = 2'd0,   // always advance
        COND_WAIT_IN  = 2'd1,   // hold until a transaction arrives
        COND_SKIP     = 2'd2,   // jump to target when no level multiply is due
        COND_WAIT_OUT = 2'd3    // hold until the output register frees, then jump
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     accept;
        logic     apply;
        logic     ld_scale;
        logic     ld_level;
        logic     ld_out;
        cond_t    cond;
        step_t    target;
    } ucode_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_in;
        logic     apply;
        logic     ld_scale;
        logic     ld_level;
        logic     ld_out;
    } dp_ctrl_t;

    typedef struct packed {
        logic mul_en;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/multi_stage_envelope_generator.sv =====
// Top level: microcode sequencer, stream handshakes and datapath of the envelope generator.
// Each item runs the fetch, apply, scale, level, product and output steps; the level step
//   runs only when a level multiply is due (tick outside off and sustain, nonzero coefficient).
// A new item is taken only after the output step, which holds while an earlier
//   result still waits; one 32x32 multiplier serves velocity scale, level and output.
// Reset (rst_n low, asynchronous): stage off, count and level zero, configuration zero,
//   sequencer at the fetch step, output empty; working registers load before use.
`default_nettype none

module multi_stage_envelope_generator (
    input  wire                              clk,
    input  wire                              rst_n,
    // Input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [mseg_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] velocity
    input  wire [mseg_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] command
    // Result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [31:0] sample, [34:32] stage, [35] active, [36] stage_changed, [39:37] zero
    output logic [mseg_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration writes
    input  wire                              cfg_we,
    input  wire [mseg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mseg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mseg_pkg::*;

    step_t      step_reg, step_next;
    ucode_t     uc;
    dp_ctrl_t   dp_ctrl;
    dp_status_t dp_status;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       in_fire;
    logic       out_free;
    logic       out_fire;

    // Control word of the current step
    mseg_ucode_rom u_rom (
        .step (step_reg),
        .word (uc)
    );

    // Take an item only at the fetch step; the output register lets a finished
    // result wait while the next item is already accepted.
    assign s_tready = uc.accept;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_fire = uc.ld_out && out_free;

    always_comb
    begin
        dp_ctrl.mul_sel  = uc.mul_sel;
        dp_ctrl.ld_in    = in_fire;
        dp_ctrl.apply    = uc.apply;
        dp_ctrl.ld_scale = uc.ld_scale;
        dp_ctrl.ld_level = uc.ld_level;
        dp_ctrl.ld_out   = out_fire;
    end

    // Step sequencing: advance, hold on a wait, or take the conditional jump
    always_comb
    begin
        case (uc.cond)
            COND_WAIT_IN:  step_next = s_tvalid ? step_t'(step_reg + 3'd1) : step_reg;
            COND_SKIP:     step_next = dp_status.mul_en ? step_t'(step_reg + 3'd1) : uc.target;
            COND_WAIT_OUT: step_next = out_free ? uc.target : step_reg;
            default:       step_next = step_t'(step_reg + 3'd1);
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (out_fire)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_FETCH;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    mseg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .status    (dp_status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (s_tuser),
        .in_vel    (s_tdata),
        .out_data  (m_tdata)
    );

    // An accepted transaction always starts the command step next
    a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step_reg == STEP_APPLY))
        else $error("accepted transaction did not reach the apply step");

    // A loaded result is presented in the following cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |=> m_tvalid)
        else $error("loaded result not presented");

    // The active flag agrees with the reported stage
    a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35] == (m_tdata[34:32] != STG_OFF)))
        else $error("active flag disagrees with stage");

endmodule

`default_nettype wire

// ===== hdl/mseg_ucode_rom.sv =====
// Microcode read-only table: one control word per program step.
`default_nettype none

module mseg_ucode_rom (
    input  mseg_pkg::step_t  step,
    output mseg_pkg::ucode_t word
);
    import mseg_pkg::*;

    always_comb
    begin
        word = '{mul_sel: MUL_NONE, accept: 1'b0, apply: 1'b0, ld_scale: 1'b0,
                 ld_level: 1'b0, ld_out: 1'b0, cond: COND_NEXT, target: STEP_FETCH};
        case (step)
            STEP_FETCH:
            begin
                word.accept = 1'b1;
                word.cond   = COND_WAIT_IN;
            end
            STEP_APPLY:
            begin
                word.apply   = 1'b1;
                word.mul_sel = MUL_DEPTH_VEL;
            end
            STEP_SCALE:
            begin
                word.ld_scale = 1'b1;
                word.mul_sel  = MUL_LEVEL_COEF;
                word.cond     = COND_SKIP;
                word.target   = STEP_PROD;
            end
            STEP_LEVEL:
            begin
                word.ld_level = 1'b1;
            end
            STEP_PROD:
            begin
                word.mul_sel = MUL_LEVEL_SCALE;
            end
            STEP_OUT:
            begin
                word.ld_out = 1'b1;
                word.cond   = COND_WAIT_OUT;
                word.target = STEP_FETCH;
            end
            default:
            begin
                word.cond   = COND_WAIT_OUT;
                word.target = STEP_FETCH;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/mseg_datapath.sv =====
// Datapath: configuration, envelope state, shared multiplier and output register.
`default_nettype none

module mseg_datapath (
    input  wire                                clk,
    input  wire                                rst_n,
    input  mseg_pkg::dp_ctrl_t                 ctrl,
    output mseg_pkg::dp_status_t               status,
    input  wire                                cfg_we,
    input  wire [mseg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [mseg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire [mseg_pkg::S_TUSER_W-1:0]      in_cmd,
    input  wire [mseg_pkg::S_TDATA_W-1:0]      in_vel,
    output logic [mseg_pkg::M_TDATA_W-1:0]     out_data
);
    import mseg_pkg::*;

    function automatic logic [LEVEL_W-1:0] sat_shift30(input logic [PROD_W-1:0] p);
        logic [LEVEL_W-1:0] r;
        begin
            if (p[PROD_W-1:PROD_W-2] != 2'b00)
                r = '1;
            else
                r = p[PROD_W-3:30];
            return r;
        end
    endfunction

    // Configuration
    logic [CFG_DATA_W-1:0] stage_word_reg [0:5];
    logic [LEVEL_W-1:0]    floor_reg;
    logic [VEL_W-1:0]      depth_reg;

    // Envelope state
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [LEVEL_W-1:0] count_reg, count_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               mul_en_reg, mul_en_next;

    // Working registers
    cmd_t               cmd_reg, cmd_next;
    logic [VEL_W-1:0]   vel_reg, vel_next;
    logic [STAGE_W-1:0] before_reg, before_next;
    logic [LEVEL_W-1:0] coef_reg, coef_next;
    logic [LEVEL_W-1:0] scale_reg, scale_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [CFG_DATA_W-1:0] cur_word;
    logic [LEVEL_W-1:0]    cnt_base;
    logic [VEL_W-1:0]      depth_c;
    logic [LEVEL_W-1:0]    bias;
    logic [LEVEL_W-1:0]    mul_a;
    logic [LEVEL_W-1:0]    mul_b;
    logic [STAGE_W-1:0]    out_stage;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                stage_word_reg[i] <= '0;
            floor_reg <= '0;
            depth_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD:     stage_word_reg[0] <= cfg_data;
                CFG_ATTACK:   stage_word_reg[1] <= cfg_data;
                CFG_DECAY1:   stage_word_reg[2] <= cfg_data;
                CFG_DECAY2:   stage_word_reg[3] <= cfg_data;
                CFG_RELEASE1: stage_word_reg[4] <= cfg_data;
                CFG_RELEASE2: stage_word_reg[5] <= cfg_data;
                CFG_FLOOR:    floor_reg <= cfg_data[LEVEL_W-1:0];
                CFG_DEPTH:    depth_reg <= cfg_data[VEL_W-1:0];
                default:      ;
            endcase
        end
    end

    // Word of the current stage; off and sustain never read it
    always_comb
    begin
        case (stage_reg)
            STG_HOLD:     cur_word = stage_word_reg[0];
            STG_ATTACK:   cur_word = stage_word_reg[1];
            STG_DECAY1:   cur_word = stage_word_reg[2];
            STG_DECAY2:   cur_word = stage_word_reg[3];
            STG_RELEASE1: cur_word = stage_word_reg[4];
            STG_RELEASE2: cur_word = stage_word_reg[5];
            default:      cur_word = '0;
        endcase
    end

    // Velocity scale: depth*vel + (1 - depth) in Q2.30
    always_comb
    begin
        depth_c = (depth_reg > ONE_Q15) ? ONE_Q15 : depth_reg;
        bias    = {1'b0, ONE_Q15 - depth_c, 15'd0};
    end

    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_DEPTH_VEL:
            begin
                mul_a = {16'd0, depth_c};
                mul_b = {16'd0, vel_reg};
            end
            MUL_LEVEL_COEF:
            begin
                mul_a = level_reg;
                mul_b = coef_reg;
            end
            MUL_LEVEL_SCALE:
            begin
                mul_a = level_reg;
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        stage_next  = stage_reg;
        count_next  = count_reg;
        level_next  = level_reg;
        mul_en_next = mul_en_reg;
        cmd_next    = cmd_reg;
        vel_next    = vel_reg;
        before_next = before_reg;
        coef_next   = coef_reg;
        scale_next  = scale_reg;
        prod_next   = prod_reg;
        out_next    = out_reg;
        cnt_base    = count_reg;
        out_stage   = stage_reg;

        if (ctrl.ld_in)
        begin
            cmd_next = cmd_t'(in_cmd);
            vel_next = in_vel;
        end

        if (ctrl.apply)
        begin
            before_next = stage_reg;
            mul_en_next = 1'b0;
            case (cmd_reg)
                CMD_TICK:
                begin
                    if (!(stage_reg inside {STG_OFF, STG_SUSTAIN}))
                    begin
                        coef_next   = cur_word[LEVEL_W-1:0];
                        mul_en_next = (cur_word[LEVEL_W-1:0] != '0);
                        if (count_reg >= cur_word[CFG_DATA_W-1:LEVEL_W])
                        begin
                            // Advance; release2 wraps to off
                            stage_next = stage_reg + 3'd1;
                            cnt_base   = '0;
                        end
                        count_next = (cnt_base == '1) ? cnt_base : cnt_base + 32'd1;
                    end
                end
                CMD_NOTE_ON:
                begin
                    stage_next = STG_HOLD;
                    count_next = '0;
                    level_next = floor_reg;
                end
                CMD_RELEASE:
                begin
                    stage_next = STG_RELEASE1;
                    count_next = '0;
                end
                default:
                begin
                    stage_next = STG_OFF;
                    count_next = '0;
                    level_next = floor_reg;
                end
            endcase
        end

        if (ctrl.ld_level)
            level_next = sat_shift30(prod_reg);

        if (ctrl.ld_scale)
            scale_next = prod_reg[LEVEL_W-1:0] + bias;

        if (ctrl.mul_sel != MUL_NONE)
            prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

        if (ctrl.ld_out)
            out_next = {3'd0, (out_stage != before_reg), (out_stage != STG_OFF),
                        out_stage, sat_shift30(prod_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= STG_OFF;
            count_reg  <= '0;
            level_reg  <= '0;
            mul_en_reg <= 1'b0;
        end
        else
        begin
            stage_reg  <= stage_next;
            count_reg  <= count_next;
            level_reg  <= level_next;
            mul_en_reg <= mul_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        vel_reg    <= vel_next;
        before_reg <= before_next;
        coef_reg   <= coef_next;
        scale_reg  <= scale_next;
        prod_reg   <= prod_next;
        out_reg    <= out_next;
    end

    assign status.mul_en = mul_en_reg;
    assign out_data      = out_reg;

endmodule

`default_nettype wire

// ===== tb/sv/mseg_envelope_checker.sv =====
`timescale 1ns / 1ps
// Watches the envelope generator's streams and register writes and checks every result.
module mseg_envelope_checker (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    input  wire [mseg_pkg::S_TDATA_W-1:0]    s_tdata,    // [15:0] velocity
    input  wire [mseg_pkg::S_TUSER_W-1:0]    s_tuser,    // [1:0] command
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    // [31:0] sample, [34:32] stage, [35] active, [36] stage_changed, [39:37] zero
    input  wire [mseg_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire                              cfg_we,
    input  wire [mseg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mseg_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               mismatches,
    output int                               outstanding,
    output int                               checked,
    output int                               stage_moves
);
    import mseg_pkg::*;

    // Same layout as m_tdata, sample in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic               changed;
        logic               active;
        logic [STAGE_W-1:0] stage;
        logic [LEVEL_W-1:0] sample;
    } envelope_out_t;

    logic [CFG_DATA_W-1:0] stage_word [0:7];
    logic [LEVEL_W-1:0]    floor_q30;
    logic [VEL_W-1:0]      depth_q15;

    logic [STAGE_W-1:0]    cur_stage;
    logic [31:0]           dwell;
    logic [LEVEL_W-1:0]    level_q30;

    envelope_out_t         pending_samples [$];
    envelope_out_t         got;
    envelope_out_t         want;

    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] envelope mismatch: %s", $time, what);
    endtask

    // Q2.30 multiply, truncated and saturated to 32 bits
    function automatic logic [LEVEL_W-1:0] q30_product(input logic [31:0] a,
                                                       input logic [63:0] b);
        logic [127:0] p;
        p = {96'd0, a} * {64'd0, b};
        p = p >> 30;
        return (p > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    task automatic step_envelope(input cmd_t cmd, input logic [VEL_W-1:0] vel);
        logic [STAGE_W-1:0] prior;
        logic [31:0]        coef;
        logic [31:0]        dur;
        logic [VEL_W-1:0]   depth;
        logic [63:0]        scale;
        envelope_out_t      r;
        prior = cur_stage;
        case (cmd)
            CMD_TICK:
                if (cur_stage != STG_OFF && cur_stage != STG_SUSTAIN)
                begin
                    coef = stage_word[cur_stage][31:0];
                    dur  = stage_word[cur_stage][63:32];
                    if (dwell >= dur)
                    begin
                        cur_stage = cur_stage + 3'd1;   // release2 wraps to off
                        dwell     = '0;
                    end
                    if (coef != '0)
                        level_q30 = q30_product(level_q30, {32'd0, coef});
                    if (dwell != '1)
                        dwell = dwell + 32'd1;
                end
            CMD_NOTE_ON:
            begin
                cur_stage = STG_HOLD;
                dwell     = '0;
                level_q30 = floor_q30;
            end
            CMD_RELEASE:
            begin
                cur_stage = STG_RELEASE1;
                dwell     = '0;
            end
            default:
            begin
                cur_stage = STG_OFF;
                dwell     = '0;
                level_q30 = floor_q30;
            end
        endcase
        depth = (depth_q15 > ONE_Q15) ? ONE_Q15 : depth_q15;
        scale = 64'(depth) * 64'(vel) + (64'(ONE_Q15 - depth) << 15);
        r.pad     = '0;
        r.changed = (cur_stage != prior);
        r.active  = (cur_stage != STG_OFF);
        r.stage   = cur_stage;
        r.sample  = q30_product(level_q30, scale);
        pending_samples.insert(pending_samples.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                stage_word[i] = '0;
            floor_q30   = '0;
            depth_q15   = '0;
            cur_stage   = STG_OFF;
            dwell       = '0;
            level_q30   = '0;
            mismatches  = 0;
            checked     = 0;
            stage_moves = 0;
            pending_samples.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOLD:     stage_word[STG_HOLD]     = cfg_data;
                    CFG_ATTACK:   stage_word[STG_ATTACK]   = cfg_data;
                    CFG_DECAY1:   stage_word[STG_DECAY1]   = cfg_data;
                    CFG_DECAY2:   stage_word[STG_DECAY2]   = cfg_data;
                    CFG_RELEASE1: stage_word[STG_RELEASE1] = cfg_data;
                    CFG_RELEASE2: stage_word[STG_RELEASE2] = cfg_data;
                    CFG_FLOOR:    floor_q30 = cfg_data[LEVEL_W-1:0];
                    CFG_DEPTH:    depth_q15 = cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = envelope_out_t'(m_tdata);
                if (pending_samples.size() == 0)
                begin
                    flag($sformatf("result %h with nothing pending", m_tdata));
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (got.sample !== want.sample)
                        flag($sformatf("sample %h, want %h", got.sample, want.sample));
                    if (got.stage !== want.stage)
                        flag($sformatf("stage %0d, want %0d", got.stage, want.stage));
                    if (got.active !== want.active)
                        flag($sformatf("active %b, want %b", got.active, want.active));
                    if (got.changed !== want.changed)
                        flag($sformatf("stage_changed %b, want %b", got.changed, want.changed));
                    if (got.pad !== want.pad)
                        flag($sformatf("pad bits %b, want zero", got.pad));
                    if (want.changed)
                        stage_moves++;
                end
                checked++;
            end
            if (s_tvalid && s_tready)
                step_envelope(cmd_t'(s_tuser), s_tdata[VEL_W-1:0]);
            outstanding <= outstanding + int'(s_tvalid && s_tready)
                                       - int'(m_tvalid && m_tready);
        end
    end

endmodule

// ===== tb/sv/multi_stage_envelope_generator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the envelope generator: clock, reset, stimulus, register phases and verdict.
module multi_stage_envelope_generator_tb;
    import mseg_pkg::*;

    // Drive every input to a known value from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;     // [15:0] velocity
    logic [S_TUSER_W-1:0]   s_tuser   = '0;     // [1:0] command
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [31:0] sample, [34:32] stage, [35] active, [36] stage_changed, [39:37] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int checked;
    int stage_moves;
    int items_sent = 0;
    int settings_used = 0;

    // When set, neither side inserts idle cycles
    logic calm = 1'b0;

    multi_stage_envelope_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mseg_envelope_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .stage_moves (stage_moves)
    );

    always #5 clk = ~clk;

    // Stall the result side at random, except in calm stretches
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // Hard stop: far beyond the slowest legal run of roughly a thousand items
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    // Offer one transaction, with random idle cycles ahead of it, and hold it until taken.
    // Leave s_tvalid high afterwards so back-to-back items need no second assignment.
    task automatic send_item(input cmd_t cmd, input logic [VEL_W-1:0] vel);
        while (!calm && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= vel;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop the input valid and wait until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Keep cfg_we high across consecutive writes; the caller lowers it after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Duration in the high half, coefficient in the low half.
    // Keep durations short most of the time so notes walk through all stages.
    function automatic logic [CFG_DATA_W-1:0] rand_stage_word();
        logic [31:0] dur;
        logic [31:0] coef;
        case ($urandom_range(9))
            0:       dur = $urandom;
            1:       dur = 32'hFFFF_FFFF;
            default: dur = $urandom_range(6);
        endcase
        case ($urandom_range(7))
            0:       coef = '0;
            1:       coef = 32'hFFFF_FFFF;
            2:       coef = $urandom;
            default: coef = $urandom_range(32'h4800_0000, 32'h3000_0000);
        endcase
        return {dur, coef};
    endfunction

    // Mostly legal Q1.15 velocities, sometimes any 16-bit pattern
    function automatic logic [VEL_W-1:0] rand_velocity();
        if ($urandom_range(4) == 0)
            return VEL_W'($urandom);
        return VEL_W'($urandom_range(32768));
    endfunction

    // Load all eight registers: all zero, all ones, or a random mix
    task automatic configure(input int flavor);
        logic [LEVEL_W-1:0] floor_pick;
        logic [VEL_W-1:0]   depth_pick;
        settings_used++;
        if (flavor == 0)
        begin
            write_reg(CFG_HOLD,     '0);
            write_reg(CFG_ATTACK,   '0);
            write_reg(CFG_DECAY1,   '0);
            write_reg(CFG_DECAY2,   '0);
            write_reg(CFG_RELEASE1, '0);
            write_reg(CFG_RELEASE2, '0);
            write_reg(CFG_FLOOR,    '0);
            write_reg(CFG_DEPTH,    '0);
        end
        else if (flavor == 1)
        begin
            write_reg(CFG_HOLD,     '1);
            write_reg(CFG_ATTACK,   '1);
            write_reg(CFG_DECAY1,   '1);
            write_reg(CFG_DECAY2,   '1);
            write_reg(CFG_RELEASE1, '1);
            write_reg(CFG_RELEASE2, '1);
            write_reg(CFG_FLOOR,    64'h0000_0000_FFFF_FFFF);
            write_reg(CFG_DEPTH,    64'h0000_0000_0000_FFFF);
        end
        else
        begin
            case ($urandom_range(3))
                0:       floor_pick = '0;
                1:       floor_pick = '1;
                2:       floor_pick = 32'h4000_0000;
                default: floor_pick = $urandom;
            endcase
            case ($urandom_range(4))
                0:       depth_pick = '0;
                1:       depth_pick = ONE_Q15;
                2:       depth_pick = '1;
                3:       depth_pick = VEL_W'($urandom);
                default: depth_pick = VEL_W'($urandom_range(32768));
            endcase
            write_reg(CFG_HOLD,     rand_stage_word());
            write_reg(CFG_ATTACK,   rand_stage_word());
            write_reg(CFG_DECAY1,   rand_stage_word());
            write_reg(CFG_DECAY2,   rand_stage_word());
            write_reg(CFG_RELEASE1, rand_stage_word());
            write_reg(CFG_RELEASE2, rand_stage_word());
            write_reg(CFG_FLOOR,    {32'd0, floor_pick});
            write_reg(CFG_DEPTH,    {48'd0, depth_pick});
        end
        cfg_we <= 1'b0;
    endtask

    // One note: note-on, a run of ticks, usually a release and its tail.
    // Mix in stray commands and resets now and then.
    task automatic play_note();
        logic [VEL_W-1:0] vel;
        int               ticks;
        vel = rand_velocity();
        if ($urandom_range(9) == 0)
            send_item(cmd_t'($urandom_range(3)), rand_velocity());
        send_item(CMD_NOTE_ON, vel);
        ticks = $urandom_range(30);
        for (int k = 0; k < ticks; k++)
            send_item(CMD_TICK, ($urandom_range(7) == 0) ? rand_velocity() : vel);
        case ($urandom_range(7))
            0:       send_item(CMD_RESET, vel);
            1:       ;   // no release: next note-on retriggers mid-envelope
            default: send_item(CMD_RELEASE, vel);
        endcase
        ticks = $urandom_range(15);
        for (int k = 0; k < ticks; k++)
            send_item(CMD_TICK, vel);
    endtask

    initial
    begin
        // Hold reset at the start, then release it once for good
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: short known stage timings so every transition shows up.
        // Hold has a zero coefficient (level kept), decay1 a zero duration (leaves at once),
        // release2 a zero coefficient and then the wrap back to off.
        settings_used++;
        write_reg(CFG_HOLD,     {32'd2, 32'h0000_0000});
        write_reg(CFG_ATTACK,   {32'd3, 32'h6000_0000});
        write_reg(CFG_DECAY1,   {32'd0, 32'h2000_0000});
        write_reg(CFG_DECAY2,   {32'd1, 32'h3C00_0000});
        write_reg(CFG_RELEASE1, {32'd2, 32'h2000_0000});
        write_reg(CFG_RELEASE2, {32'd1, 32'h0000_0000});
        write_reg(CFG_FLOOR,    64'h0000_0000_4000_0000);
        write_reg(CFG_DEPTH,    {48'd0, ONE_Q15});
        cfg_we <= 1'b0;

        send_item(CMD_RESET,   ONE_Q15);     // reset loads the floor level
        send_item(CMD_TICK,    16'h0000);    // tick while off does nothing
        send_item(CMD_RELEASE, 16'hFFFF);    // release works even from off
        send_item(CMD_NOTE_ON, ONE_Q15);
        send_item(CMD_NOTE_ON, 16'h0001);    // retrigger in hold: stage unchanged
        send_item(CMD_TICK,    16'h0000);
        send_item(CMD_TICK,    16'hFFFF);    // velocity above one
        for (int k = 0; k < 10; k++)         // hold, attack, decay1, decay2, sustain
            send_item(CMD_TICK, ONE_Q15);
        send_item(CMD_RELEASE, ONE_Q15);
        for (int k = 0; k < 6; k++)          // release1, release2, wrap to off
            send_item(CMD_TICK, 16'h7FFF);
        send_item(CMD_RESET,   16'h0000);
        drain();

        // Random part: extremes first, then random settings; one phase without idling
        for (int phase = 0; phase < 7; phase++)
        begin
            configure(phase);
            calm = (phase == 3);
            while (items_sent < 25 + 115 * (phase + 1))
                play_note();
            drain();
        end
        calm = 1'b0;

        // Allow any stray result to surface before the verdict
        repeat (20) @(posedge clk);

        $display("Run: %0d transactions over %0d register settings, %0d results checked.",
                 items_sent, settings_used, checked);
        $display("Stage changes observed: %0d, mismatches: %0d.", stage_moves, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
